FILE: hw/rtl/dlp_pkg.sv
// Shared types, character codes and limits for the detection record line parser.
// Used by dlp_conf_conv, dlp_field_parser and detection_record_line_parser.
package dlp_pkg;

  // Line and field limits
  localparam int LINE_LIMIT          = 64;
  localparam int LEN_W               = $clog2(LINE_LIMIT);
  localparam int MATERIAL_MIN        = 1;
  localparam int MATERIAL_MAX        = 6;
  // The reciprocal table in conf_mult/conf_shift covers up to five fraction digits
  localparam int FRAC_DIGITS_MAX     = 5;
  localparam logic [17:0] ACCUM_CAP  = 18'h3FFFF;
  localparam logic [15:0] CONF_ONE   = 16'd32768;

  // Character codes
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field numbers within a line
  localparam logic [2:0] FLD_TAG      = 3'd0;
  localparam logic [2:0] FLD_MATERIAL = 3'd1;
  localparam logic [2:0] FLD_CX       = 3'd2;
  localparam logic [2:0] FLD_CY       = 3'd3;
  localparam logic [2:0] FLD_CONF     = 3'd4;
  localparam logic [2:0] FLD_CAMERA   = 3'd5;

  // Confidence source codes
  localparam logic [1:0] CONF_SEL_ZERO = 2'd0;
  localparam logic [1:0] CONF_SEL_ONE  = 2'd1;
  localparam logic [1:0] CONF_SEL_FRAC = 2'd2;

  // One finished result
  typedef struct packed {
    logic               record_ok;
    logic               overrun;
    logic [2:0]         material;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        confidence_q15;
    logic [7:0]         camera;
    logic [7:0]         line_checksum;
  } dlp_result_t;

  // Fraction conversion request from the parser
  typedef struct packed {
    logic        load;
    logic [16:0] value;
    logic [2:0]  digits;
  } dlp_conv_req_t;

  // ceil(2^(15+S)/10^k), with S large enough that the result is exact for value < 10^k
  function automatic logic [32:0] conf_mult(input logic [2:0] digits);
    logic [32:0] m;
    unique case (digits)
      3'd1:    m = 33'd419431;
      3'd2:    m = 33'd5368710;
      3'd3:    m = 33'd34359739;
      3'd4:    m = 33'd439804652;
      3'd5:    m = 33'd5629499535;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

  // Right shift S that goes with conf_mult
  function automatic logic [5:0] conf_shift(input logic [2:0] digits);
    logic [5:0] s;
    unique case (digits)
      3'd1:    s = 6'd7;
      3'd2:    s = 6'd14;
      3'd3:    s = 6'd20;
      3'd4:    s = 6'd27;
      3'd5:    s = 6'd34;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/detection_record_line_parser.sv
// Detection record line parser: parses "M,material,cx,cy,conf,cam" lines from serial bytes.
// A newline byte goes from the input register through the parse logic into the
// result register, where its result is held.
// Throughput: one byte per cycle; a byte waits in the input register only while
// a finished result is stalled at the output.
// Reset (rst_n low, synchronous) empties both registers and clears the parser's line and number state.
module detection_record_line_parser
  import dlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_record_ok,
  output logic               out_overrun,
  output logic [2:0]         out_material,
  output logic signed [15:0] out_center_x,
  output logic signed [15:0] out_center_y,
  output logic [15:0]        out_confidence_q15,
  output logic [7:0]         out_camera,
  output logic [7:0]         out_line_checksum
);

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          out_valid_r;
  dlp_result_t   out_r;
  logic          advance;
  logic          go;
  logic          res_valid;
  dlp_result_t   res;
  dlp_conv_req_t conv_req;
  logic [15:0]   conf_frac;

  // Pipeline moves when the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign go       = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte_r <= in_rx_byte;
  end

  dlp_field_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .rx_byte   (in_byte_r),
    .conf_frac (conf_frac),
    .res_valid (res_valid),
    .res       (res),
    .conv_req  (conv_req)
  );

  dlp_conf_conv u_conv (
    .clk      (clk),
    .req      (conv_req),
    .conf_q15 (conf_frac)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) out_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_record_ok      = out_r.record_ok;
  assign out_overrun        = out_r.overrun;
  assign out_material       = out_r.material;
  assign out_center_x       = out_r.center_x;
  assign out_center_y       = out_r.center_y;
  assign out_confidence_q15 = out_r.confidence_q15;
  assign out_camera         = out_r.camera;
  assign out_line_checksum  = out_r.line_checksum;

  // An accepted byte lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_valid_r)
    else $error("accepted request not captured");

  // Failed or overrun records carry zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_ok |-> (out_material == '0) && (out_center_x == '0) &&
      (out_center_y == '0) && (out_confidence_q15 == '0) && (out_camera == '0))
    else $error("invalid record with nonzero fields");

  // Good records are in range and never flagged as overrun
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_ok |-> !out_overrun &&
      (8'(out_material) >= 8'(MATERIAL_MIN)) && (8'(out_material) <= 8'(MATERIAL_MAX)) &&
      (out_confidence_q15 <= CONF_ONE))
    else $error("valid record out of range");

endmodule

FILE: hw/rtl/dlp_conf_conv.sv
// Decimal fraction to Q1.15 converter: floor(value * 32768 / 10^digits).
// Reciprocal multiply with a registered product; depends on dlp_pkg.
module dlp_conf_conv
  import dlp_pkg::*;
(
  input  logic          clk,
  input  dlp_conv_req_t req,
  output logic [15:0]   conf_q15
);

  logic [16:0] value_r;
  logic [2:0]  digits_r;
  logic [2:0]  prod_digits_r;
  logic [49:0] prod_r;
  logic [49:0] shifted;

  // Operand capture when the confidence field closes
  always_ff @(posedge clk) begin
    if (req.load) begin
      value_r  <= req.value;
      digits_r <= req.digits;
    end
  end

  // Product stage, runs every cycle off the held operands
  always_ff @(posedge clk) begin
    prod_r        <= 50'(value_r) * 50'(conf_mult(digits_r));
    prod_digits_r <= digits_r;
  end

  // value < 10^digits, so the quotient stays below 32768
  assign shifted  = prod_r >> conf_shift(prod_digits_r);
  assign conf_q15 = shifted[15:0];

endmodule

FILE: hw/rtl/dlp_field_parser.sv
// Per-byte line parser: field state, number accumulation, range checks and results.
// Depends on dlp_pkg; takes the converted fraction from dlp_conf_conv.
module dlp_field_parser
  import dlp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [7:0]    rx_byte,
  input  logic [15:0]   conf_frac,
  output logic          res_valid,
  output dlp_result_t   res,
  output dlp_conv_req_t conv_req
);

  localparam logic signed [18:0] V_MAT_MIN = 19'(MATERIAL_MIN);
  localparam logic signed [18:0] V_MAT_MAX = 19'(MATERIAL_MAX);
  localparam logic signed [18:0] V_S16_MIN = -19'sd32768;
  localparam logic signed [18:0] V_S16_MAX = 19'sd32767;
  localparam logic signed [18:0] V_U8_MAX  = 19'sd255;

  // Line and number state
  logic [2:0]       field_r, field_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [17:0]      accum_r, accum_nxt;
  logic             neg_r, neg_nxt;
  logic             sign_r, sign_nxt;
  logic             digit_r, digit_nxt;
  logic             point_r, point_nxt;
  logic [16:0]      frac_r, frac_nxt;
  logic [2:0]       fdig_r, fdig_nxt;
  logic             fnz_r, fnz_nxt;
  logic             bad_r, bad_nxt;
  logic             disc_r, disc_nxt;

  // Values of fields closed so far
  logic [2:0]        mat_r, mat_nxt;
  logic [15:0]       cx_r, cx_nxt;
  logic [15:0]       cy_r, cy_nxt;
  logic [1:0]        csel_r, csel_nxt;

  logic              is_digit;
  logic [3:0]        dval;
  logic [21:0]       accum_ext;
  logic [20:0]       frac_ext;
  logic signed [18:0] num_v;
  logic              close_ok;
  logic [15:0]       conf_val;
  logic              clr_num;
  logic              clr_line;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign dval      = rx_byte[3:0];
  assign accum_ext = 22'(accum_r) * 22'd10 + 22'(dval);
  assign frac_ext  = 21'(frac_r) * 21'd10 + 21'(dval);
  assign num_v     = neg_r ? -$signed({1'b0, accum_r}) : $signed({1'b0, accum_r});

  // Field close check for the current field
  always_comb begin
    close_ok = 1'b0;
    if (digit_r) begin
      unique case (field_r)
        FLD_TAG:      close_ok = 1'b1;
        FLD_MATERIAL: close_ok = (num_v >= V_MAT_MIN) && (num_v <= V_MAT_MAX);
        FLD_CX,
        FLD_CY:       close_ok = (num_v >= V_S16_MIN) && (num_v <= V_S16_MAX);
        FLD_CONF:     close_ok = neg_r ? (accum_r == '0) && !fnz_r
                                       : (accum_r == '0) || ((accum_r == 18'd1) && !fnz_r);
        FLD_CAMERA:   close_ok = (num_v >= 19'sd0) && (num_v <= V_U8_MAX);
        default:      close_ok = 1'b0;
      endcase
    end
  end

  // Held confidence value
  always_comb begin
    unique case (csel_r)
      CONF_SEL_ONE:  conf_val = CONF_ONE;
      CONF_SEL_FRAC: conf_val = conf_frac;
      default:       conf_val = '0;
    endcase
  end

  // Next state for one byte
  always_comb begin
    field_nxt = field_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    sign_nxt  = sign_r;
    digit_nxt = digit_r;
    point_nxt = point_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    fnz_nxt   = fnz_r;
    bad_nxt   = bad_r;
    disc_nxt  = disc_r;
    mat_nxt   = mat_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    csel_nxt  = csel_r;
    res_valid = 1'b0;
    res       = '0;
    conv_req  = '0;
    clr_num   = 1'b0;
    clr_line  = 1'b0;

    if (go) begin
      priority if (disc_r) begin
        if (rx_byte == CH_NL) begin
          disc_nxt = 1'b0;
          clr_line = 1'b1;
        end
      end else if (rx_byte == CH_CR) begin
        // carriage return is dropped
      end else if (rx_byte == CH_NL) begin
        if (len_r != '0) begin
          res_valid         = 1'b1;
          res.record_ok     = !bad_r && (field_r == FLD_CAMERA) && close_ok;
          res.line_checksum = xor_r;
          if (res.record_ok) begin
            res.material       = mat_r;
            res.center_x       = $signed(cx_r);
            res.center_y       = $signed(cy_r);
            res.confidence_q15 = conf_val;
            res.camera         = num_v[7:0];
          end
          clr_line = 1'b1;
        end
      end else if (len_r >= LEN_W'(LINE_LIMIT - 1)) begin
        // line too long: report and drop up to the next newline
        res_valid         = 1'b1;
        res.overrun       = 1'b1;
        res.line_checksum = xor_r;
        clr_line          = 1'b1;
        disc_nxt          = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
        xor_nxt = xor_r ^ rx_byte;
        if (!bad_r) begin
          priority if (rx_byte == CH_COMMA) begin
            if (field_r >= FLD_CAMERA) begin
              bad_nxt = 1'b1;
            end else begin
              if (!close_ok) bad_nxt = 1'b1;
              unique case (field_r)
                FLD_MATERIAL: mat_nxt = num_v[2:0];
                FLD_CX:       cx_nxt  = num_v[15:0];
                FLD_CY:       cy_nxt  = num_v[15:0];
                FLD_CONF: begin
                  conv_req.load   = 1'b1;
                  conv_req.value  = frac_r;
                  conv_req.digits = fdig_r;
                  if (neg_r)                 csel_nxt = CONF_SEL_ZERO;
                  else if (accum_r == '0)    csel_nxt = CONF_SEL_FRAC;
                  else                       csel_nxt = CONF_SEL_ONE;
                end
                default: ;
              endcase
              field_nxt = field_r + 3'd1;
              clr_num   = 1'b1;
            end
          end else if (field_r == FLD_TAG) begin
            if ((rx_byte == CH_M) && !digit_r) digit_nxt = 1'b1;
            else                               bad_nxt   = 1'b1;
          end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
            if (digit_r || sign_r || point_r) begin
              bad_nxt = 1'b1;
            end else begin
              sign_nxt = 1'b1;
              neg_nxt  = (rx_byte == CH_MINUS);
            end
          end else if ((field_r == FLD_CONF) && (rx_byte == CH_POINT)) begin
            if (point_r) bad_nxt   = 1'b1;
            else         point_nxt = 1'b1;
          end else if (is_digit) begin
            digit_nxt = 1'b1;
            if ((field_r == FLD_CONF) && point_r) begin
              if (fdig_r < 3'(FRAC_DIGITS_MAX)) begin
                frac_nxt = frac_ext[16:0];
                fdig_nxt = fdig_r + 3'd1;
              end
              if (dval != 4'd0) fnz_nxt = 1'b1;
            end else begin
              accum_nxt = (accum_ext > 22'(ACCUM_CAP)) ? ACCUM_CAP : accum_ext[17:0];
            end
          end else begin
            bad_nxt = 1'b1;
          end
        end
      end
    end

    // Number and line clears
    if (clr_num || clr_line) begin
      accum_nxt = '0;
      neg_nxt   = 1'b0;
      sign_nxt  = 1'b0;
      digit_nxt = 1'b0;
      point_nxt = 1'b0;
      frac_nxt  = '0;
      fdig_nxt  = '0;
      fnz_nxt   = 1'b0;
    end
    if (clr_line) begin
      field_nxt = FLD_TAG;
      len_nxt   = '0;
      xor_nxt   = '0;
      bad_nxt   = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= FLD_TAG;
      len_r   <= '0;
      xor_r   <= '0;
      accum_r <= '0;
      neg_r   <= 1'b0;
      sign_r  <= 1'b0;
      digit_r <= 1'b0;
      point_r <= 1'b0;
      frac_r  <= '0;
      fdig_r  <= '0;
      fnz_r   <= 1'b0;
      bad_r   <= 1'b0;
      disc_r  <= 1'b0;
    end else begin
      field_r <= field_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      accum_r <= accum_nxt;
      neg_r   <= neg_nxt;
      sign_r  <= sign_nxt;
      digit_r <= digit_nxt;
      point_r <= point_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
      fnz_r   <= fnz_nxt;
      bad_r   <= bad_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // Held field values, only read once every field of the line closed cleanly
  always_ff @(posedge clk) begin
    mat_r  <= mat_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    csel_r <= csel_nxt;
  end

endmodule

FILE: tb/tb_detection_record_line_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for detection_record_line_parser: serial text lines go in, and each
// parsed record is compared with a line-level predictor kept in a scoreboard class.
// Depends on dlp_pkg and the parser RTL only.
module tb_detection_record_line_parser
  import dlp_pkg::*;
();

  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving on either side
  localparam int TOTAL_BYTES  = 1100;
  localparam int CALM_TAIL    = 150;   // last random bytes sent with no idling

  // Line predictor and store of expected records
  class line_scoreboard;
    dlp_result_t        expected_q[$];
    int                 errors;
    logic [2:0]         fld;
    int unsigned        stored_len;
    logic [7:0]         xor_acc;
    logic [17:0]        mag;
    bit                 neg, sign_done, digit_done, point_done;
    logic [16:0]        frac_val;
    int unsigned        frac_cnt;
    bit                 frac_nz, bad, skipping;
    logic [2:0]         hold_mat;
    logic signed [15:0] hold_x, hold_y;
    logic [15:0]        hold_conf;
    logic [7:0]         hold_cam;

    function new();
      errors   = 0;
      skipping = 0;
      clear_line();
    endfunction

    function void clear_number();
      mag        = '0;
      neg        = 0;
      sign_done  = 0;
      digit_done = 0;
      point_done = 0;
      frac_val   = '0;
      frac_cnt   = 0;
      frac_nz    = 0;
    endfunction

    function void clear_line();
      clear_number();
      fld        = FLD_TAG;
      stored_len = 0;
      xor_acc    = '0;
      bad        = 0;
      hold_mat   = '0;
      hold_x     = '0;
      hold_y     = '0;
      hold_conf  = '0;
      hold_cam   = '0;
    endfunction

    // Closes the current field: range check, and latch its value when good
    function bit field_closes();
      int              v;
      longint unsigned scale;
      if (!digit_done) return 0;
      if (fld == FLD_TAG) return 1;
      if (fld == FLD_CONF) begin
        if (neg) begin
          hold_conf = '0;
          return mag == 0 && !frac_nz;
        end
        if (mag == 0) begin
          scale = 1;
          repeat (frac_cnt) scale *= 10;
          hold_conf = 16'((longint'(frac_val) * 32768) / scale);
          return 1;
        end
        if (mag == 1 && !frac_nz) begin
          hold_conf = CONF_ONE;
          return 1;
        end
        return 0;
      end
      v = neg ? -int'(mag) : int'(mag);
      case (fld)
        FLD_MATERIAL: begin
          if (v < MATERIAL_MIN || v > MATERIAL_MAX) return 0;
          hold_mat = v[2:0];
          return 1;
        end
        FLD_CX: begin
          if (v < -32768 || v > 32767) return 0;
          hold_x = v[15:0];
          return 1;
        end
        FLD_CY: begin
          if (v < -32768 || v > 32767) return 0;
          hold_y = v[15:0];
          return 1;
        end
        FLD_CAMERA: begin
          if (v < 0 || v > 255) return 0;
          hold_cam = v[7:0];
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    // Accepted input request: advance the line state, queue a record when one is due
    function void note_request(logic [7:0] c);
      dlp_result_t     r;
      longint unsigned grown;
      bit              ok;
      // dropping the rest of an overrun line
      if (skipping) begin
        if (c == CH_NL) begin
          skipping = 0;
          clear_line();
        end
        return;
      end
      if (c == CH_CR) return;
      // end of line: empty lines give nothing
      if (c == CH_NL) begin
        if (stored_len == 0) return;
        ok = !bad && fld == FLD_CAMERA && field_closes();
        r = '0;
        r.record_ok = ok;
        if (ok) begin
          r.material       = hold_mat;
          r.center_x       = hold_x;
          r.center_y       = hold_y;
          r.confidence_q15 = hold_conf;
          r.camera         = hold_cam;
        end
        r.line_checksum = xor_acc;
        expected_q.push_back(r);
        clear_line();
        return;
      end
      // line too long: overrun record, byte not stored
      if (stored_len >= LINE_LIMIT - 1) begin
        r = '0;
        r.overrun       = 1'b1;
        r.line_checksum = xor_acc;
        expected_q.push_back(r);
        clear_line();
        skipping = 1;
        return;
      end
      stored_len++;
      xor_acc ^= c;
      if (bad) return;
      if (c == CH_COMMA) begin
        if (fld >= FLD_CAMERA) begin
          bad = 1;
        end else begin
          if (!field_closes()) bad = 1;
          fld++;
          clear_number();
        end
      end else if (fld == FLD_TAG) begin
        if (c == CH_M && !digit_done) digit_done = 1;
        else bad = 1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        if (digit_done || sign_done || point_done) begin
          bad = 1;
        end else begin
          sign_done = 1;
          neg       = (c == CH_MINUS);
        end
      end else if (fld == FLD_CONF && c == CH_POINT) begin
        if (point_done) bad = 1;
        else point_done = 1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        digit_done = 1;
        if (fld == FLD_CONF && point_done) begin
          // only the first few fraction digits count; later nonzero ones still matter
          if (frac_cnt < FRAC_DIGITS_MAX) begin
            frac_val = frac_val * 10 + (c - CH_ZERO);
            frac_cnt++;
          end
          if (c != CH_ZERO) frac_nz = 1;
        end else begin
          grown = longint'(mag) * 10 + (c - CH_ZERO);
          mag   = (grown > ACCUM_CAP) ? ACCUM_CAP : grown[17:0];
        end
      end else begin
        bad = 1;
      end
    endfunction

    function void field_check(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Accepted output request: compare with the oldest expected record
    function void check_result(dlp_result_t got);
      dlp_result_t want;
      if (expected_q.size() == 0) begin
        $error("record with none expected: checksum %0h", got.line_checksum);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      field_check("record_ok", want.record_ok, got.record_ok);
      field_check("overrun", want.overrun, got.overrun);
      field_check("material", want.material, got.material);
      field_check("center_x", want.center_x, got.center_x);
      field_check("center_y", want.center_y, got.center_y);
      field_check("confidence_q15", want.confidence_q15, got.confidence_q15);
      field_check("camera", want.camera, got.camera);
      field_check("line_checksum", want.line_checksum, got.line_checksum);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_record_ok;
  logic               out_overrun;
  logic [2:0]         out_material;
  logic signed [15:0] out_center_x;
  logic signed [15:0] out_center_y;
  logic [15:0]        out_confidence_q15;
  logic [7:0]         out_camera;
  logic [7:0]         out_line_checksum;

  line_scoreboard sb;
  logic [7:0]     line_buf[$];
  int             gap_odds = 0;  // chance in eighths of an idle burst, 0 = none
  int             sent_bytes = 0;
  int             stall_left = 0;
  int             quiet_cycles = 0;
  logic [7:0]     oddities[10] = '{8'h00, 8'h20, 8'h09, 8'h65, 8'h45, CH_POINT, CH_PLUS,
                                   CH_MINUS, CH_COMMA, 8'hFF};

  detection_record_line_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_ok      (out_record_ok),
    .out_overrun        (out_overrun),
    .out_material       (out_material),
    .out_center_x       (out_center_x),
    .out_center_y       (out_center_y),
    .out_confidence_q15 (out_confidence_q15),
    .out_camera         (out_camera),
    .out_line_checksum  (out_line_checksum)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
      stall_left = $urandom_range(1, 18);
      out_stall <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    dlp_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.record_ok      = out_record_ok;
      got.overrun        = out_overrun;
      got.material       = out_material;
      got.center_x       = out_center_x;
      got.center_y       = out_center_y;
      got.confidence_q15 = out_confidence_q15;
      got.camera         = out_camera;
      got.line_checksum  = out_line_checksum;
      sb.check_result(got);
    end
  end

  // Watchdog: ends the run when no request moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte request, with an optional idle burst before it
  task automatic send_byte(input logic [7:0] b);
    if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(b);
  endtask

  task automatic send_line(input bit with_cr);
    if (with_cr) line_buf.push_back(CH_CR);
    line_buf.push_back(CH_NL);
    sent_bytes += line_buf.size();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Mostly in range, sometimes at or just past the limits, sometimes saturating
  function automatic int pick_value(int lo, int hi);
    case ($urandom_range(0, 19))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      4: return hi + 300000;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic string int_text(int val);
    string s;
    s = $sformatf("%0d", val < 0 ? -val : val);
    if ($urandom_range(0, 9) == 0) s = {"0", s};
    if (val < 0) s = {"-", s};
    else if ($urandom_range(0, 5) == 0) s = {"+", s};
    else if (val == 0 && $urandom_range(0, 3) == 0) s = {"-", s};
    return s;
  endfunction

  function automatic string conf_text();
    string s;
    case ($urandom_range(0, 9))
      0: s = "1";
      1: s = "1.000";
      2: s = "0";
      3: s = "-0.0";
      4: s = $sformatf("%0d.%0d", $urandom_range(0, 3), $urandom_range(0, 9));
      5: s = $sformatf("-0.%0d", $urandom_range(0, 9));
      default: begin
        s = ($urandom_range(0, 3) == 0) ? "." : "0.";
        repeat ($urandom_range(1, 8)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
    endcase
    return s;
  endfunction

  // Well-formed six-field record with random content, sometimes a stray CR inside
  function automatic void put_record();
    put_text($sformatf("M,%s,%s,%s,%s,%s",
                       int_text(pick_value(MATERIAL_MIN, MATERIAL_MAX)),
                       int_text(pick_value(-32768, 32767)),
                       int_text(pick_value(-32768, 32767)),
                       conf_text(),
                       int_text(pick_value(0, 255))));
    if ($urandom_range(0, 7) == 0)
      line_buf.insert($urandom_range(0, line_buf.size()), CH_CR);
  endfunction

  initial begin
    string directed[$];
    int    kind;
    int    pos;
    sb = new();
    directed = '{"M,1,0,0,0.5,0", "M,6,-32768,32767,1,255", "M,1,32768,0,0,0",
                 "M,2,0,-32769,0,0", "M,0,1,1,0.25,1", "M,7,1,1,0.25,1", "",
                 "M,3,+5,-0,1.00000,+255", "M,1,0,0,1.00001,0", "M,1,0,0,0.99999999,0",
                 "M,1,0,0,-0.000,-0", "M,1,0,0,-0.1,0", "M,1,0,0,.5,0", "M,1,0,0,.,0",
                 "M,1,0,0,0.5,0,", "M,1,0,0,0.5", "M,1,0,0,0.5,256",
                 "M,1,999999999,0,0,0", "M,1,0,0,0.5e1,0", "M, 1,0,0,0.5,0",
                 "MM,1,0,0,0.5,0", "M,1,--1,0,0.5,0", "M,1,0,0,0..5,0", "M,,0,0,0.5,0",
                 "M,4,0,0,01.000,0", "M,1,0,0,0.00001,0"};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: field limits, signs, fraction forms, bad characters, field counts
    foreach (directed[i]) begin
      gap_odds = $urandom_range(0, 3);
      put_text(directed[i]);
      send_line(i % 3 == 0);
    end
    // NUL and a high byte inside a line
    put_text("M,1,0");
    line_buf.push_back(8'h00);
    put_text(",0,0.5,0");
    send_line(0);
    put_text("M,1,0,0,0.5,");
    line_buf.push_back(8'hFF);
    send_line(0);
    // longest line that still ends normally, then an overrun and its dropped tail
    put_text("M,1,");
    repeat (LINE_LIMIT - 5) line_buf.push_back(CH_ZERO);
    send_line(0);
    put_text("M,1,");
    repeat (LINE_LIMIT - 4) line_buf.push_back(CH_NINE);
    put_text("M,1,0,0,0.5,0");
    send_line(1);
    put_text("M,2,10,-10,0.75,9");
    send_line(0);

    // Random lines, mostly well-formed, up to the byte budget of the whole run
    while (sent_bytes < TOTAL_BYTES) begin
      gap_odds = (sent_bytes > TOTAL_BYTES - CALM_TAIL) ? 0 : $urandom_range(0, 3);
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        put_record();
      end else if (kind < 15) begin
        // one byte replaced, removed or added
        put_record();
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: line_buf[pos] = 8'($urandom_range(0, 255));
          1: line_buf.delete(pos);
          default: line_buf.insert(pos, oddities[$urandom_range(0, 9)]);
        endcase
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 17) begin
        // near or past the line limit
        repeat ($urandom_range(60, 75))
          line_buf.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(48, 57)) :
                                                           8'($urandom_range(128, 255)));
      end else if (kind == 18) begin
        // one field too many or too few
        put_record();
        if ($urandom_range(0, 1) == 0) begin
          put_text({",", int_text(pick_value(0, 255))});
        end else begin
          while (line_buf.size() != 0 && line_buf[$] != CH_COMMA) void'(line_buf.pop_back());
          void'(line_buf.pop_back());
        end
      end
      send_line($urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dlp_pkg.sv
hw/rtl/dlp_conf_conv.sv
hw/rtl/dlp_field_parser.sv
hw/rtl/detection_record_line_parser.sv
tb/tb_detection_record_line_parser.sv
